// ===== rtl/core/segment_circle_intersect_test_macros.svh =====
// Assertion macros for the segment / circle test RTL
`ifndef SEGMENT_CIRCLE_INTERSECT_TEST_MACROS_SVH
`define SEGMENT_CIRCLE_INTERSECT_TEST_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SCI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sci_pkg.sv =====
// Package: shared constants for the segment / circle crossing test
`timescale 1ns / 1ps
package sci_pkg;
  // Default coordinate width in bits
  localparam int COORD_WIDTH = 24;
  // Register stages in each half of the pipeline
  localparam int HALF_STAGES = 3;
endpackage

// ===== rtl/core/sci_in_if.sv =====
// Interface: input beat carrying one segment and one circle
`timescale 1ns / 1ps
interface sci_in_if #(
  parameter int W = sci_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] centre_x;
  logic signed [W-1:0] centre_y;
  logic        [W-2:0] radius;

  modport source (output valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                  radius, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                radius, output ready);
endinterface

// ===== rtl/core/sci_out_if.sv =====
// Interface: result beat carrying the crossing flag
`timescale 1ns / 1ps
interface sci_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ===== rtl/core/sci_terms.sv =====
// Front half: differences, products and the quadratic's coefficients
`timescale 1ns / 1ps
module sci_terms #(
  parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  start_x,
  input  logic signed [COORD_WIDTH-1:0]  start_y,
  input  logic signed [COORD_WIDTH-1:0]  end_x,
  input  logic signed [COORD_WIDTH-1:0]  end_y,
  input  logic signed [COORD_WIDTH-1:0]  centre_x,
  input  logic signed [COORD_WIDTH-1:0]  centre_y,
  input  logic        [COORD_WIDTH-2:0]  radius,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic        [2*COORD_WIDTH:0]   a,
  output logic signed [2*COORD_WIDTH+3:0] h,
  output logic signed [2*COORD_WIDTH+3:0] c,
  output logic        [2*COORD_WIDTH:0]   cross_mag,
  output logic        [2*COORD_WIDTH-3:0] r2
);
  localparam int W  = COORD_WIDTH;
  localparam int NS = sci_pkg::HALF_STAGES;
  localparam int P  = 2 * W + 2;
  localparam int S  = 2 * W + 4;
  localparam int M  = 2 * W + 1;

  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  logic signed [W:0]   dx, dy, fx, fy;
  logic        [W-2:0] r1;
  logic signed [P-1:0] pxx, pyy, qx, qy, gx, gy, kx, ky;
  logic        [2*W-3:0] rr;
  logic signed [S-1:0] a_sum, cross_sum, cross_abs;

  // Stage ready: a stage loads when empty or when the next one moves
  assign rdy[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Stage 1: direction and offset vectors
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
      dy <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
      fx <= {start_x[W-1], start_x} - {centre_x[W-1], centre_x};
      fy <= {start_y[W-1], start_y} - {centre_y[W-1], centre_y};
      r1 <= radius;
    end
  end

  // Stage 2: the products used by the coefficient sums and cross product
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pxx <= dx * dx;
      pyy <= dy * dy;
      qx  <= fx * dx;
      qy  <= fy * dy;
      gx  <= fx * fx;
      gy  <= fy * fy;
      kx  <= fx * dy;
      ky  <= fy * dx;
      rr  <= r1 * r1;
    end
  end

  // Stage 3: coefficient sums and the cross product magnitude
  assign a_sum     = S'(pxx) + S'(pyy);
  assign cross_sum = S'(kx) - S'(ky);
  assign cross_abs = cross_sum[S-1] ? -cross_sum : cross_sum;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      a         <= a_sum[M-1:0];
      h         <= S'(qx) + S'(qy);
      c         <= S'(gx) + S'(gy) - S'(rr);
      cross_mag <= cross_abs[M-1:0];
      r2        <= rr;
    end
  end
endmodule

// ===== rtl/core/sci_decide.sv =====
// Back half: end point signs, split discriminant products, final flag
`timescale 1ns / 1ps
`include "segment_circle_intersect_test_macros.svh"
module sci_decide #(
  parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic        [2*COORD_WIDTH:0]   a,
  input  logic signed [2*COORD_WIDTH+3:0] h,
  input  logic signed [2*COORD_WIDTH+3:0] c,
  input  logic        [2*COORD_WIDTH:0]   cross_mag,
  input  logic        [2*COORD_WIDTH-3:0] r2,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit
);
  localparam int W  = COORD_WIDTH;
  localparam int NS = sci_pkg::HALF_STAGES;
  localparam int S  = 2 * W + 4;
  localparam int M  = 2 * W + 1;
  localparam int L  = W + 1;
  localparam int HB = M - L;
  localparam int Q  = 2 * M;

  logic [NS-1:0] v;
  logic [NS-1:0] rdy;

  logic signed [S-1:0] f1, ah;
  logic [M-1:0] r2_ext;
  logic c_neg, c_pos, f_neg, f_pos, h_le0;

  // Stage 4 registers
  logic deg4, deg_val4, cross_hit4, need_disc4;
  logic [2*HB-1:0]   m_hh, ra_hh;
  logic [HB+L-1:0]   m_hl, ra_hl, ra_lh;
  logic [2*L-1:0]    m_ll, ra_ll;
  // Stage 5 registers
  logic deg5, deg_val5, cross_hit5, need_disc5;
  logic [Q-1:0] sq, ra;

  // Stage ready chain
  assign rdy[NS-1] = !v[NS-1] || out_ready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
    assign rdy[k] = !v[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = v[NS-1];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Value of the quadratic at the far end point, and the vertex bound
  assign f1     = S'(a) + c + (h <<< 1);
  assign ah     = S'(a) + h;
  assign c_neg  = c[S-1];
  assign c_pos  = !c[S-1] && (c != '0);
  assign f_neg  = f1[S-1];
  assign f_pos  = !f1[S-1] && (f1 != '0);
  assign h_le0  = h[S-1] || (h == '0);
  assign r2_ext = M'(r2);

  // Stage 4: classify end points, start split products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      deg4       <= (a == '0);
      deg_val4   <= c_neg;
      cross_hit4 <= !(c_pos && f_pos) && !(c_neg && f_neg);
      need_disc4 <= c_pos && f_pos && h_le0 && !ah[S-1];
      m_hh  <= cross_mag[M-1:L] * cross_mag[M-1:L];
      m_hl  <= cross_mag[M-1:L] * cross_mag[L-1:0];
      m_ll  <= cross_mag[L-1:0] * cross_mag[L-1:0];
      ra_hh <= r2_ext[M-1:L] * a[M-1:L];
      ra_hl <= r2_ext[M-1:L] * a[L-1:0];
      ra_lh <= r2_ext[L-1:0] * a[M-1:L];
      ra_ll <= r2_ext[L-1:0] * a[L-1:0];
    end
  end

  // Stage 5: assemble cross^2 and r^2 * a
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      deg5       <= deg4;
      deg_val5   <= deg_val4;
      cross_hit5 <= cross_hit4;
      need_disc5 <= need_disc4;
      sq <= (Q'(m_hh) << (2 * L)) + (Q'(m_hl) << (L + 1)) + Q'(m_ll);
      ra <= (Q'(ra_hh) << (2 * L)) + ((Q'(ra_hl) + Q'(ra_lh)) << L) + Q'(ra_ll);
    end
  end

  // Stage 6: discriminant sign and the flag
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      hit <= deg5 ? deg_val5 : (cross_hit5 || (need_disc5 && (ra >= sq)));
    end
  end

  `SCI_ASSERT_NOW(a_deg_zero_terms, in_valid && (a == '0), (cross_mag == '0) && (h == '0), "degenerate segment with nonzero cross or dot term")
  `SCI_ASSERT_NOW(a_class_exclusive, v[1] && cross_hit5, !need_disc5, "sign change and discriminant path both selected")
  `SCI_ASSERT_NEXT(a_hold_result, v[2] && !out_ready, v[2] && $stable(hit), "stalled result lost or changed")
endmodule

// ===== rtl/core/segment_circle_intersect_test.sv =====
// Top level: segment / circle boundary crossing test, six-stage pipeline
//
//  channel  | dir | beat fields
//  ---------+-----+------------------------------------------------------
//  item     | in  | start_x start_y end_x end_y centre_x centre_y radius
//  result   | out | hit
//
// One item enters per cycle unless a result stall backs up the chain; each item is registered in every stage.
// The span is three stages of differences, products and coefficient sums,
// two stages of split wide multiply for the discriminant, and one for the flag.
// Reset clears only the valid bits; no item is in flight afterward.
// A stall on result holds each occupied stage; an empty stage upstream still
// fills, and ready ripples back through the chain within the same cycle.
`timescale 1ns / 1ps
module segment_circle_intersect_test #(
  parameter int COORD_WIDTH = sci_pkg::COORD_WIDTH
) (
  input logic      clk,
  input logic      rst,
  sci_in_if.sink   item,
  sci_out_if.source result
);
  localparam int W = COORD_WIDTH;

  logic                 t_valid, t_ready;
  logic        [2*W:0]   t_a, t_cross_mag;
  logic signed [2*W+3:0] t_h, t_c;
  logic        [2*W-3:0] t_r2;

  // Coefficient stages
  sci_terms #(.COORD_WIDTH(W)) u_terms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .start_x   (item.start_x),
    .start_y   (item.start_y),
    .end_x     (item.end_x),
    .end_y     (item.end_y),
    .centre_x  (item.centre_x),
    .centre_y  (item.centre_y),
    .radius    (item.radius),
    .out_valid (t_valid),
    .out_ready (t_ready),
    .a         (t_a),
    .h         (t_h),
    .c         (t_c),
    .cross_mag (t_cross_mag),
    .r2        (t_r2)
  );

  // Decision stages
  sci_decide #(.COORD_WIDTH(W)) u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (t_valid),
    .in_ready  (t_ready),
    .a         (t_a),
    .h         (t_h),
    .c         (t_c),
    .cross_mag (t_cross_mag),
    .r2        (t_r2),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .hit       (result.hit)
  );
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the segment / circle crossing test: random and directed beats, scoreboard check
`timescale 1ns / 1ps
class hit_scoreboard;
  bit hit_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Compute the exact crossing flag for one segment / circle pair
  function bit crossing(logic signed [23:0] sx, logic signed [23:0] sy,
                        logic signed [23:0] ex, logic signed [23:0] ey,
                        logic signed [23:0] cx, logic signed [23:0] cy,
                        logic [22:0] rad);
    logic signed [159:0] dx, dy, fx, fy, rr, a, h, c, f1;
    bit res;
    dx = 160'(signed'(ex)) - 160'(signed'(sx));
    dy = 160'(signed'(ey)) - 160'(signed'(sy));
    fx = 160'(signed'(sx)) - 160'(signed'(cx));
    fy = 160'(signed'(sy)) - 160'(signed'(cy));
    rr = {137'd0, rad};
    a = dx * dx + dy * dy;
    h = fx * dx + fy * dy;
    c = fx * fx + fy * fy - rr * rr;
    res = 0;
    if (a == 0) begin
      res = (c < 0);
    end else begin
      f1 = a + c + h + h;
      if ((c <= 0 && f1 >= 0) || (c >= 0 && f1 <= 0)) begin
        res = 1;
      end else if (c > 0 && f1 > 0) begin
        // vertex of the parabola must fall inside the segment
        if (-h >= 0 && a + h >= 0) res = (h * h - a * c >= 0);
      end
    end
    return res;
  endfunction

  function void note_item(logic signed [23:0] sx, logic signed [23:0] sy,
                          logic signed [23:0] ex, logic signed [23:0] ey,
                          logic signed [23:0] cx, logic signed [23:0] cy,
                          logic [22:0] rad);
    hit_q.push_back(crossing(sx, sy, ex, ey, cx, cy, rad));
  endfunction

  function void check_result(bit got);
    bit want;
    if (hit_q.size() == 0) begin
      $display("%0t: unexpected result hit=%0b", $time, got);
      errors++;
      return;
    end
    want = hit_q.pop_front();
    if (want != got) begin
      $display("%0t: hit mismatch expected %0b actual %0b", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst;
  sci_in_if item_bus ();
  sci_out_if result_bus ();
  hit_scoreboard sb;
  int idle_cycles;
  int rx_mode;

  segment_circle_intersect_test i_dut (
    .clk(clk), .rst(rst), .item(item_bus.sink), .result(result_bus.source)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Send one item, holding it until accepted
  task automatic send_item(logic [23:0] sx, logic [23:0] sy, logic [23:0] ex,
                           logic [23:0] ey, logic [23:0] cx, logic [23:0] cy,
                           logic [22:0] rad);
    item_bus.valid <= 1;
    item_bus.start_x <= sx; item_bus.start_y <= sy;
    item_bus.end_x <= ex; item_bus.end_y <= ey;
    item_bus.centre_x <= cx; item_bus.centre_y <= cy;
    item_bus.radius <= rad;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(sx, sy, ex, ey, cx, cy, rad);
  endtask

  // Drop valid for a random gap after a burst
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 6);
    if (n > 0) begin
      item_bus.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random small value near a base, to keep geometry interesting
  function automatic logic [23:0] near(logic [23:0] base, int span);
    return base + 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Receiver stall pattern: phases of always-ready, random, and mostly-stalled
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 0;
      rx_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) rx_mode <= $urandom_range(0, 2);
      case (rx_mode)
        0: result_bus.ready <= 1;
        1: result_bus.ready <= 1'($urandom_range(0, 1));
        default: result_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check each accepted result and watch for stalls
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_bus.valid && result_bus.ready) sb.check_result(result_bus.hit);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [23:0] sx, sy, ex, ey, cx, cy;
    logic [22:0] rad;
    int burst, kind, rscale;
    sb = new();
    rst = 1;
    item_bus.valid = 0;
    item_bus.start_x = 0; item_bus.start_y = 0; item_bus.end_x = 0;
    item_bus.end_y = 0; item_bus.centre_x = 0; item_bus.centre_y = 0;
    item_bus.radius = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes and named special cases
    send_item(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 0, 0, 23'h7fffff);
    send_item(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 24'h800000,
              24'h7fffff, 23'h7fffff);
    send_item(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff,
              24'h7fffff, 23'h7fffff);
    send_item(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h800000,
              24'h800000, 0);
    // coincident end points inside, on, and outside
    send_item(100, 0, 100, 0, 0, 0, 200);
    send_item(200, 0, 200, 0, 0, 0, 200);
    send_item(300, 0, 300, 0, 0, 0, 200);
    send_item(0, 0, 0, 0, 0, 0, 0);
    // end point exactly on the circle
    send_item(256, 0, 1000, 1000, 0, 0, 256);
    send_item(-1000, 5, 0, 256, 0, 0, 256);
    // tangent inside, tangent beyond the segment
    send_item(-512, 256, 512, 256, 0, 0, 256);
    send_item(300, 256, 900, 256, 0, 0, 256);
    // wholly inside, crossing, missing
    send_item(-10, -10, 10, 10, 0, 0, 1000);
    send_item(-2000, 0, 2000, 0, 0, 0, 1000);
    send_item(-2000, 2000, 2000, 2000, 0, 0, 1000);
    // zero radius through and off the centre
    send_item(-50, -50, 50, 50, 0, 0, 0);
    send_item(-50, -49, 50, 51, 0, 0, 0);
    // line crosses circle but roots beyond segment
    send_item(2000, 0, 3000, 0, 0, 0, 1000);
    send_item(24'hffffff, 24'h000001, 24'h000001, 24'hffffff, 24'h555555,
              24'haaaaaa, 23'h2aaaaa);
    idle_gap();

    // Random bursts
    for (int i = 0; i < 600; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && i < 600; b++, i++) begin
        kind = $urandom_range(0, 9);
        cx = 24'($urandom); cy = 24'($urandom);
        rscale = $urandom_range(1, 22);
        rad = 23'($urandom) & ((23'd1 << rscale) - 23'd1);
        if (kind < 6) begin
          // geometry near the circle, scale matched to the radius
          sx = near(cx, 1 << rscale); sy = near(cy, 1 << rscale);
          ex = near(cx, 1 << rscale); ey = near(cy, 1 << rscale);
        end else if (kind == 6) begin
          sx = near(cx, 1 << rscale); sy = near(cy, 1 << rscale);
          ex = sx; ey = sy;
        end else begin
          sx = 24'($urandom); sy = 24'($urandom);
          ex = 24'($urandom); ey = 24'($urandom);
          rad = 23'($urandom);
        end
        send_item(sx, sy, ex, ey, cx, cy, rad);
      end
      idle_gap();
    end
    item_bus.valid <= 0;

    // Drain, then allow for pipeline latency
    while (sb.hit_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
